### hdl/first_fit_heap_allocator_macros.svh
// Assertion macros used by the checker file
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FFHA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap allocator check failed");

// next-cycle implication
`define FFHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap allocator check failed");

`endif

### hdl/ffha_pkg.sv
// Types and constants of the first-fit heap allocator
package ffha_pkg;

    localparam int unsigned HDR_BYTES = 16;
    localparam int unsigned STORE_DEPTH = 4096;
    localparam int unsigned SLOT_W = 12;
    localparam int unsigned OFF_W = 17;
    localparam logic [16:0] HEAP_MAX = 17'd65536;

    localparam logic [31:0] ID_FREE = 32'hAAAA5555;
    localparam logic [31:0] ID_USED = 32'h5555AAAA;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE = 2'd1;
    localparam logic [1:0] ACT_INIT = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD = 3'd1;
    localparam logic [2:0] ST_NOFIT = 3'd2;
    localparam logic [2:0] ST_CORRUPT = 3'd3;
    localparam logic [2:0] ST_BADFREE = 3'd4;

    localparam logic REG_HEAP_BASE = 1'b0;
    localparam logic REG_HEAP_LENGTH = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] request_size;
        logic [31:0] request_alignment;
        logic [31:0] release_address;
    } req_t;

    typedef struct packed {
        logic [31:0] payload_address;
        logic [2:0]  status;
    } rsp_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LATCH,
        OP_ALLOC_START,
        OP_FREE_START,
        OP_INIT,
        OP_READ_CUR,
        OP_READ_NXT,
        OP_CHK_CUR,
        OP_CHK_NXT,
        OP_ADVANCE,
        OP_CALC,
        OP_PLAN_TAIL,
        OP_PLAN_HEAD,
        OP_PLAN_FREE,
        OP_PLAN_MERGE,
        OP_MERGE_START,
        OP_WRITE,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] st;
        logic       addr_en;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       bad_alloc;
        logic       bad_free;
        logic       init_tiny;
        logic       cur_ok;
        logic       nxt_ok;
        logic       cf;
        logic       cu;
        logic       nf;
        logic       nu;
        logic       fits;
        logic       tail_ok;
        logic       head_ok;
        logic       wr_last;
        logic       clr_last;
        logic       rsp_free;
    } stat_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_WALK_TEST,
        S_WALK_CHK,
        S_WALK_EVAL,
        S_CALC,
        S_DECIDE,
        S_FREE_RD,
        S_FREE_CHK,
        S_FREE_EVAL,
        S_WRITE,
        S_MERGE_START,
        S_M_TEST,
        S_M_CHK1,
        S_M_EVAL1,
        S_M_CHK2,
        S_M_EVAL2,
        S_DONE
    } ctl_state_t;

    typedef enum logic [1:0] {
        RET_DONE,
        RET_MERGE0,
        RET_MERGE
    } ret_t;

endpackage

### hdl/ffha_ctrl.sv
// Controller state machine of the heap allocator
module ffha_ctrl import ffha_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    ctl_state_t state_reg, state_next;
    ret_t       ret_reg, ret_next;
    logic [2:0] st_reg, st_next;
    logic       addr_en_reg, addr_en_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            ret_reg     <= RET_DONE;
            st_reg      <= ST_OK;
            addr_en_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            st_reg      <= st_next;
            addr_en_reg <= addr_en_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        st_next      = st_reg;
        addr_en_next = addr_en_reg;
        cmd.op       = OP_NONE;
        cmd.st       = st_reg;
        cmd.addr_en  = addr_en_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                addr_en_next = 1'b0;
                st_next      = ST_OK;
                priority if (stat.action == ACT_ALLOC)
                begin
                    if (stat.bad_alloc)
                    begin
                        st_next    = ST_BAD;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.op     = OP_ALLOC_START;
                        state_next = S_WALK_TEST;
                    end
                end
                else if (stat.action == ACT_FREE)
                begin
                    if (stat.bad_free)
                    begin
                        st_next    = ST_BADFREE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.op     = OP_FREE_START;
                        state_next = S_FREE_RD;
                    end
                end
                else if (stat.action == ACT_INIT)
                begin
                    cmd.op   = OP_INIT;
                    ret_next = RET_DONE;
                    if (stat.init_tiny)
                        state_next = S_DONE;
                    else
                        state_next = S_WRITE;
                end
                else
                begin
                    st_next    = ST_BAD;
                    state_next = S_DONE;
                end
            end
            S_WALK_TEST:
            begin
                if (stat.cur_ok)
                begin
                    cmd.op     = OP_READ_CUR;
                    state_next = S_WALK_CHK;
                end
                else
                begin
                    st_next    = ST_NOFIT;
                    state_next = S_DONE;
                end
            end
            S_WALK_CHK:
            begin
                cmd.op     = OP_CHK_CUR;
                state_next = S_WALK_EVAL;
            end
            S_WALK_EVAL:
            begin
                priority if (!stat.cf && !stat.cu)
                begin
                    st_next    = ST_CORRUPT;
                    state_next = S_DONE;
                end
                else if (stat.fits)
                    state_next = S_CALC;
                else
                begin
                    cmd.op     = OP_ADVANCE;
                    state_next = S_WALK_TEST;
                end
            end
            S_CALC:
            begin
                cmd.op     = OP_CALC;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                priority if (stat.tail_ok)
                begin
                    cmd.op       = OP_PLAN_TAIL;
                    ret_next     = RET_DONE;
                    addr_en_next = 1'b1;
                    state_next   = S_WRITE;
                end
                else if (stat.head_ok)
                begin
                    cmd.op       = OP_PLAN_HEAD;
                    ret_next     = RET_DONE;
                    addr_en_next = 1'b1;
                    state_next   = S_WRITE;
                end
                else
                begin
                    cmd.op     = OP_ADVANCE;
                    state_next = S_WALK_TEST;
                end
            end
            S_FREE_RD:
            begin
                cmd.op     = OP_READ_CUR;
                state_next = S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                cmd.op     = OP_CHK_CUR;
                state_next = S_FREE_EVAL;
            end
            S_FREE_EVAL:
            begin
                if (stat.cu)
                begin
                    cmd.op     = OP_PLAN_FREE;
                    ret_next   = RET_MERGE0;
                    state_next = S_WRITE;
                end
                else
                begin
                    st_next    = ST_BADFREE;
                    state_next = S_DONE;
                end
            end
            S_WRITE:
            begin
                cmd.op = OP_WRITE;
                if (stat.wr_last)
                begin
                    unique case (ret_reg)
                        RET_DONE:   state_next = S_DONE;
                        RET_MERGE0: state_next = S_MERGE_START;
                        RET_MERGE:  state_next = S_M_TEST;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_MERGE_START:
            begin
                cmd.op     = OP_MERGE_START;
                state_next = S_M_TEST;
            end
            S_M_TEST:
            begin
                if (stat.cur_ok)
                begin
                    cmd.op     = OP_READ_CUR;
                    state_next = S_M_CHK1;
                end
                else
                    state_next = S_DONE;
            end
            S_M_CHK1:
            begin
                cmd.op     = OP_CHK_CUR;
                state_next = S_M_EVAL1;
            end
            S_M_EVAL1:
            begin
                if ((!stat.cf && !stat.cu) || !stat.nxt_ok)
                    state_next = S_DONE;
                else
                begin
                    cmd.op     = OP_READ_NXT;
                    state_next = S_M_CHK2;
                end
            end
            S_M_CHK2:
            begin
                cmd.op     = OP_CHK_NXT;
                state_next = S_M_EVAL2;
            end
            S_M_EVAL2:
            begin
                priority if (!stat.nf && !stat.nu)
                    state_next = S_DONE;
                else if (stat.cf && stat.nf)
                begin
                    cmd.op     = OP_PLAN_MERGE;
                    ret_next   = RET_MERGE;
                    state_next = S_WRITE;
                end
                else
                begin
                    cmd.op     = OP_ADVANCE;
                    state_next = S_M_TEST;
                end
            end
            S_DONE:
            begin
                if (stat.rsp_free)
                begin
                    cmd.op     = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

### hdl/ffha_dp.sv
// Datapath of the heap allocator: config registers, header store, walk registers
module ffha_dp import ffha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  req_t        req,
    output rsp_t        rsp,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata
);

    logic [64:0] mem [STORE_DEPTH];

    logic [31:0] heap_base_reg;
    logic [16:0] heap_length_reg;
    logic [31:0] act_base_reg;
    logic [16:0] act_len_reg;
    req_t        req_reg;
    logic [16:0] size_reg;
    logic [31:0] align_reg;
    logic [33:0] cur_reg, nxt_reg, end_reg;
    logic [31:0] csz_reg, nsz_reg;
    logic        cf_reg, cu_reg, nf_reg, nu_reg;
    logic [32:0] data_reg;
    logic [31:0] aoff_reg;
    logic [16:0] w_off_reg [3];
    logic [31:0] w_size_reg [3];
    logic        w_free_reg [3];
    logic [1:0]  wn_reg, wi_reg;
    logic [SLOT_W-1:0] clr_reg;
    logic [64:0] rd_reg;
    logic [15:0] rd_off_reg;
    rsp_t        rsp_reg;
    logic        rsp_valid_reg;

    function automatic logic in_heap(input logic [33:0] x, input logic [16:0] len);
        return (len >= 17'd16) && (x <= ({17'd0, len} - 34'd16));
    endfunction

    // config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg   <= '0;
            heap_length_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_HEAP_BASE)
                heap_base_reg <= pwdata;
            else
                heap_length_reg <= pwdata[16:0];
        end
    end

    assign prdata = (paddr[2] == REG_HEAP_LENGTH) ? {15'd0, heap_length_reg} : heap_base_reg;

    // header checks on the last read
    logic [31:0] rd_size, rd_sum, rd_abs;
    logic        hf, hu;
    assign rd_size = rd_reg[63:32];
    assign rd_sum  = rd_reg[31:0];
    assign rd_abs  = act_base_reg + {16'd0, rd_off_reg};
    assign hf = rd_reg[64] && (rd_off_reg[3:0] == 4'd0) && (rd_sum == (ID_FREE ^ rd_abs ^ rd_size));
    assign hu = rd_reg[64] && (rd_off_reg[3:0] == 4'd0) && (rd_sum == (ID_USED ^ rd_abs ^ rd_size));

    logic [33:0] cur_abs;
    assign cur_abs = {2'd0, act_base_reg} + cur_reg;

    // initialise
    logic [31:0] ib;
    logic [16:0] il_cap, ilen;
    logic [32:0] ilim;
    assign ib     = heap_base_reg & 32'hFFFF_FFF0;
    assign il_cap = (heap_length_reg > HEAP_MAX) ? HEAP_MAX : heap_length_reg;
    assign ilim   = 33'h1_0000_0000 - {1'b0, ib};
    assign ilen   = ({16'd0, il_cap} > ilim) ? ilim[16:0] : il_cap;

    // request checks
    logic [31:0] rq_sz, rq_al, rq_ra;
    assign rq_sz = req_reg.request_size;
    assign rq_al = req_reg.request_alignment;
    assign rq_ra = req_reg.release_address;

    // alloc arithmetic
    logic [33:0] t_val;
    logic [31:0] t_aoff, amask;
    logic [16:0] data_off;
    assign amask    = align_reg - 32'd1;
    assign t_val    = end_reg - {17'd0, size_reg};
    assign t_aoff   = t_val[31:0] & amask;
    assign data_off = data_reg[16:0] - act_base_reg[16:0];

    always_comb
    begin
        stat.action    = req_reg.action;
        stat.bad_alloc = (rq_sz == 32'd0) || (rq_sz > {15'd0, act_len_reg}) ||
                         (rq_al == 32'd0) || ((rq_al & (rq_al - 32'd1)) != 32'd0);
        stat.bad_free  = (rq_ra == 32'd0) ||
                         ({1'b0, rq_ra} < ({1'b0, act_base_reg} + 33'd16)) ||
                         ({1'b0, rq_ra} >= ({1'b0, act_base_reg} + {16'd0, act_len_reg}));
        stat.init_tiny = (ilen <= 17'd16);
        stat.cur_ok    = in_heap(cur_reg, act_len_reg);
        stat.nxt_ok    = in_heap(nxt_reg, act_len_reg);
        stat.cf        = cf_reg;
        stat.cu        = cu_reg;
        stat.nf        = nf_reg;
        stat.nu        = nu_reg;
        stat.fits      = cf_reg && (csz_reg >= {15'd0, size_reg});
        stat.tail_ok   = ({1'b0, data_reg} > (cur_abs + 34'd48));
        stat.head_ok   = (((cur_abs[31:0] + 32'd16) & amask) == 32'd0);
        stat.wr_last   = (wi_reg == (wn_reg - 2'd1));
        stat.clr_last  = (clr_reg == '1);
        stat.rsp_free  = !rsp_valid_reg || !rsp_stall;
    end

    // header store port
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr, mem_raddr;
    logic [64:0]       mem_wdata;
    logic [16:0]       w_off;
    logic [31:0]       w_size;

    assign w_off  = w_off_reg[wi_reg];
    assign w_size = w_size_reg[wi_reg];

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = w_off[15:4];
        mem_wdata = {1'b1, w_size,
                     (w_free_reg[wi_reg] ? ID_FREE : ID_USED) ^
                     (act_base_reg + {15'd0, w_off}) ^ w_size};
        mem_raddr = (cmd.op == OP_READ_NXT) ? nxt_reg[15:4] : cur_reg[15:4];
        if (cmd.op == OP_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (cmd.op == OP_WRITE)
            mem_we = (w_off[3:0] == 4'd0) && !w_off[16];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_reg <= mem[mem_raddr];
    end

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_base_reg  <= '0;
            act_len_reg   <= '0;
            clr_reg       <= '0;
            wi_reg        <= '0;
            wn_reg        <= 2'd1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.op == OP_INIT)
            begin
                act_base_reg <= ib;
                act_len_reg  <= (ilen <= 17'd16) ? 17'd0 : ilen;
            end
            unique case (cmd.op)
                OP_INIT, OP_PLAN_FREE, OP_PLAN_MERGE:
                begin
                    wn_reg <= 2'd1;
                    wi_reg <= 2'd0;
                end
                OP_PLAN_TAIL:
                begin
                    wn_reg <= (aoff_reg > 32'd16) ? 2'd3 : 2'd2;
                    wi_reg <= 2'd0;
                end
                OP_PLAN_HEAD:
                begin
                    wn_reg <= (csz_reg > ({15'd0, size_reg} + 32'd32)) ? 2'd2 : 2'd1;
                    wi_reg <= 2'd0;
                end
                OP_WRITE:
                    wi_reg <= wi_reg + 2'd1;
                default:
                    wi_reg <= wi_reg;
            endcase
            if (cmd.op == OP_RESULT)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LATCH:
                req_reg <= req;
            OP_ALLOC_START:
            begin
                size_reg  <= (rq_sz[16:0] + 17'd15) & 17'h1FFF0;
                align_reg <= (rq_al < 32'd16) ? 32'd16 : rq_al;
                cur_reg   <= '0;
            end
            OP_FREE_START:
                cur_reg <= {2'd0, rq_ra} - {2'd0, act_base_reg} - 34'd16;
            OP_INIT:
            begin
                w_off_reg[0]  <= '0;
                w_size_reg[0] <= {15'd0, ilen} - 32'd16;
                w_free_reg[0] <= 1'b1;
            end
            OP_READ_CUR:
                rd_off_reg <= cur_reg[15:0];
            OP_READ_NXT:
                rd_off_reg <= nxt_reg[15:0];
            OP_CHK_CUR:
            begin
                cf_reg  <= hf;
                cu_reg  <= hu;
                csz_reg <= rd_size;
                nxt_reg <= cur_reg + 34'd16 + {2'd0, rd_size};
                end_reg <= cur_abs + 34'd16 + {2'd0, rd_size};
            end
            OP_CHK_NXT:
            begin
                nf_reg  <= hf;
                nu_reg  <= hu;
                nsz_reg <= rd_size;
            end
            OP_ADVANCE:
                cur_reg <= nxt_reg;
            OP_MERGE_START:
                cur_reg <= '0;
            OP_CALC:
            begin
                aoff_reg <= t_aoff;
                data_reg <= t_val[32:0] - {1'b0, t_aoff};
            end
            OP_PLAN_TAIL:
            begin
                w_off_reg[0]  <= cur_reg[16:0];
                w_size_reg[0] <= data_reg[31:0] - cur_abs[31:0] - 32'd32;
                w_free_reg[0] <= 1'b1;
                w_off_reg[1]  <= data_off - 17'd16;
                w_size_reg[1] <= {15'd0, size_reg} + ((aoff_reg <= 32'd16) ? aoff_reg : 32'd0);
                w_free_reg[1] <= 1'b0;
                w_off_reg[2]  <= data_off + size_reg;
                w_size_reg[2] <= aoff_reg - 32'd16;
                w_free_reg[2] <= 1'b1;
            end
            OP_PLAN_HEAD:
            begin
                data_reg <= cur_abs[32:0] + 33'd16;
                if (csz_reg > ({15'd0, size_reg} + 32'd32))
                begin
                    w_off_reg[0]  <= cur_reg[16:0] + 17'd16 + size_reg;
                    w_size_reg[0] <= csz_reg - {15'd0, size_reg} - 32'd16;
                    w_free_reg[0] <= 1'b1;
                    w_off_reg[1]  <= cur_reg[16:0];
                    w_size_reg[1] <= {15'd0, size_reg};
                    w_free_reg[1] <= 1'b0;
                end
                else
                begin
                    w_off_reg[0]  <= cur_reg[16:0];
                    w_size_reg[0] <= csz_reg;
                    w_free_reg[0] <= 1'b0;
                end
            end
            OP_PLAN_FREE:
            begin
                w_off_reg[0]  <= cur_reg[16:0];
                w_size_reg[0] <= csz_reg;
                w_free_reg[0] <= 1'b1;
            end
            OP_PLAN_MERGE:
            begin
                w_off_reg[0]  <= cur_reg[16:0];
                w_size_reg[0] <= csz_reg + 32'd16 + nsz_reg;
                w_free_reg[0] <= 1'b1;
            end
            OP_RESULT:
            begin
                rsp_reg.payload_address <= cmd.addr_en ? data_reg[31:0] : 32'd0;
                rsp_reg.status          <= cmd.st;
            end
            default:
                req_reg <= req_reg;
        endcase
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

### hdl/first_fit_heap_allocator.sv
// First-fit heap allocator top level: controller plus datapath
// After reset the block sweeps its 4096-entry header store clear, one entry a cycle,
// and takes no item until then; configuration writes are taken at any time.
// Allocate and free walk the block chain through the header store, which has one
// read port and one write port. Allocate dispatches, tests, reads and checks each
// block walked, calculates and decides on a carve at each free block big enough,
// writes its headers (at most three) and posts the result. Free checks and rewrites
// the header, starts a merge pass over the whole chain that checks each block and
// the next and merges two free neighbours, then posts the result. Initialise writes
// one free header unless the heap is too small. A rejected item goes from dispatch
// to posting its result. A finished result waits in an output register while the next item is accepted.
module first_fit_heap_allocator import ffha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cmd_t  cmd;
    stat_t stat;

    assign pready = 1'b1;

    ffha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ffha_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata)
    );

endmodule

### hdl/ffha_checker.sv
// Port-level checks of the heap allocator and their bind
`include "first_fit_heap_allocator_macros.svh"

module ffha_checker import ffha_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    `FFHA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
    `FFHA_ASSERT_NOW(a_fail_no_addr, rsp_valid && (rsp.status != ST_OK), rsp.payload_address == 32'd0)
    `FFHA_ASSERT_NOW(a_status_code, rsp_valid, rsp.status <= ST_BADFREE)
    `FFHA_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall)

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);
